// ----- rtl/asp_pkg.sv -----
// Shared constants, register codes and record types of the atlas shelf packer.
`timescale 1ns / 1ps

package asp_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_ENTRIES_DEF   = 1024;
  localparam int unsigned MAX_SIDE_LOG2_DEF = 12;
  localparam int unsigned MIN_SIDE_LOG2     = 6;

  // Fixed field widths.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned LOG_W      = 4;
  localparam int unsigned PAD_W      = 4;
  localparam int unsigned CORNER_W   = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER    = 2'd3;

  // Configuration reset values.
  localparam logic [LOG_W-1:0]    INIT_SIDE_RST = 4'd10;
  localparam logic [LOG_W-1:0]    MAX_SIDE_RST  = 4'd12;
  localparam logic [PAD_W-1:0]    PAD_RST       = 4'd2;
  localparam logic [CORNER_W-1:0] CORNER_RST    = 6'd8;

  // Stored size of one entry.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } rect_t;

  // Stored placement of one entry.
  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } place_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             placed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [LOG_W-1:0] side_log2;
    logic             grew;
    logic             store_full;
  } result_t;

endpackage

// ----- rtl/atlas_shelf_packer_with_regrow.sv -----
// Shelf rectangle packer for a square, growable atlas, with its entry stores.
`timescale 1ns / 1ps

// The packer keeps every rectangle it is given as a numbered entry and puts it on
// horizontal shelves in a square atlas, left to right from a pen, opening a new shelf
// below when a row is full; the first shelf starts after a reserved corner. When a
// rectangle does not fit and growth is still allowed, the side doubles and all stored
// entries, the new one included, are packed again in arrival order, doubling again if
// that replay fails. A place request is fitted in the fit state and a read request is
// answered from the read state; clear, unused codes and a refused place (entry store
// full) are finished in the cycle of acceptance. A place that grows the atlas adds, for
// every doubling, one pass over the stored entries, since the replay reads one stored
// size per cycle from a synchronous memory with a registered read port; a pass that
// fails stops at the failing entry. Sizes and placements sit in two synchronous
// memories of MAX_ENTRIES entries each; neither needs clearing after reset, because
// reads past the entry count return an unplaced result. One request is in work at a
// time, and a finished result waits in an output register so the next request can be
// accepted while it is unclaimed.
module atlas_shelf_packer_with_regrow #(
  parameter int unsigned MAX_ENTRIES   = asp_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MAX_SIDE_LOG2 = asp_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [asp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [asp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [asp_pkg::FUNC_W-1:0]      func_i,
  input  logic [asp_pkg::DIM_W-1:0]       rect_width_i,
  input  logic [asp_pkg::DIM_W-1:0]       rect_height_i,
  input  logic [asp_pkg::IDX_W-1:0]       read_index_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [asp_pkg::IDX_W-1:0]       entry_index_o,
  output logic                            placed_o,
  output logic [asp_pkg::POS_W-1:0]       pos_x_o,
  output logic [asp_pkg::POS_W-1:0]       pos_y_o,
  output logic [asp_pkg::LOG_W-1:0]       side_log2_o,
  output logic                            grew_o,
  output logic                            store_full_o
);
  import asp_pkg::*;

  // Entry address, entry count, request index and pen widths.
  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned KW   = (IW > CNTW) ? IW : CNTW;
  // Pens hold values below four times the largest side; pen y saturates at the top of that range.
  localparam int unsigned PW   = MAX_SIDE_LOG2 + 2;
  // Width of the fit arithmetic, wide enough for every sum without overflow.
  localparam int unsigned CW   = ((PW > DIM_W) ? PW : DIM_W) + 3;

  localparam logic [LOG_W-1:0] SIDE_MAX = LOG_W'(MAX_SIDE_LOG2);
  localparam logic [LOG_W-1:0] SIDE_MIN = LOG_W'(MIN_SIDE_LOG2);
  localparam logic [LOG_W-1:0] SIDE_RST = (INIT_SIDE_RST > SIDE_MAX) ? SIDE_MAX
                                                                     : INIT_SIDE_RST;
  localparam logic [PW-1:0]    PEN_SAT    = '1;
  localparam logic [CNTW-1:0]  COUNT_FULL = CNTW'(MAX_ENTRIES);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIT    = 3'd1;
  localparam logic [2:0] ST_REPLAY = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  // Configuration registers.
  logic [LOG_W-1:0]    init_side_q, max_side_q;
  logic [PAD_W-1:0]    pad_q;
  logic [CORNER_W-1:0] corner_q;

  // Control and atlas state.
  logic [2:0]      state_q, state_d;
  logic [LOG_W-1:0] side_q, side_d;
  logic [PW-1:0]   pen_x_q, pen_x_d, pen_y_q, pen_y_d, shelf_h_q, shelf_h_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] rk_q, rk_d;
  logic [AW-1:0]   fk_q, fk_d;
  logic            dv_q, dv_d;
  logic            grew_q, grew_d;
  logic            out_valid_q, out_valid_d;

  // Payload registers of the request in work and of the result.
  logic [AW-1:0]    idx_q, idx_d;
  rect_t            cur_q, cur_d;
  logic             rd_ok_q, rd_ok_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  result_t          hold_q, hold_d;
  result_t          out_q, out_d;

  // Entry stores.
  rect_t   size_mem [MAX_ENTRIES];
  place_t  place_mem [MAX_ENTRIES];
  rect_t   size_rd_q;
  place_t  place_rd_q;
  logic    size_we, size_re, pl_we, pl_re;
  logic [AW-1:0] size_wa, size_ra, pl_wa, pl_ra;
  rect_t   size_wd;
  place_t  pl_wd;

  // Miscellaneous combinational signals.
  logic             accept, out_free, fin;
  result_t          fin_res;
  logic [LOG_W-1:0] start_side, grow_lim;
  logic             may_grow;
  logic [IW-1:0]    ridx_ext, idx_ext;

  // Fit unit signals.
  rect_t          fit_rect;
  logic [CW-1:0]  side_px, w_c, h_c, p_c, px_c, py_c, sh_c;
  logic [CW-1:0]  x_eff, y_try, sh_eff, x_next;
  logic           zero, too_big, wrap, fail_y;
  logic           fit_grow;
  place_t         fit_pl;
  logic [PW-1:0]  fit_pen_x, fit_pen_y, fit_sh;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ridx_ext   = IW'(read_index_i);
  assign idx_ext    = IW'(idx_q);

  // The side after clear is the configured one clamped to the legal range, and growth
  // stops at the smaller of the configured and the built-in maximum.
  always_comb begin
    if (init_side_q < SIDE_MIN) begin
      start_side = SIDE_MIN;
    end else if (init_side_q > SIDE_MAX) begin
      start_side = SIDE_MAX;
    end else begin
      start_side = init_side_q;
    end
    grow_lim = (max_side_q > SIDE_MAX) ? SIDE_MAX : max_side_q;
    may_grow = (side_q < grow_lim);
  end

  // Fit unit: tries one rectangle against the current pens. The new item is fitted
  // from its request register, replayed entries from the size memory read port.
  always_comb begin
    fit_rect = (state_q == ST_FIT) ? cur_q : size_rd_q;
    side_px  = CW'(1) << side_q;
    w_c      = CW'(fit_rect.w);
    h_c      = CW'(fit_rect.h);
    p_c      = CW'(pad_q);
    px_c     = CW'(pen_x_q);
    py_c     = CW'(pen_y_q);
    sh_c     = CW'(shelf_h_q);

    zero    = (fit_rect.w == '0) || (fit_rect.h == '0);
    too_big = (w_c + (p_c << 1) > side_px) || (h_c + (p_c << 1) > side_px);
    wrap    = (px_c + w_c + p_c > side_px);
    x_eff   = wrap ? p_c : px_c;
    y_try   = wrap ? (py_c + sh_c + p_c) : py_c;
    sh_eff  = wrap ? '0 : sh_c;
    fail_y  = (y_try + h_c + p_c > side_px);
    x_next  = x_eff + w_c + p_c;

    fit_grow = !zero && (too_big || fail_y) && may_grow;

    fit_pl.placed = !zero && !too_big && !fail_y;
    fit_pl.x      = fit_pl.placed ? x_eff[POS_W-1:0] : '0;
    fit_pl.y      = fit_pl.placed ? y_try[POS_W-1:0] : '0;

    fit_pen_x = pen_x_q;
    fit_pen_y = pen_y_q;
    fit_sh    = shelf_h_q;
    if (!zero && !too_big) begin
      // A shelf wrap stays in effect even when the rectangle then fails.
      if (wrap) begin
        fit_pen_x = PW'(p_c);
        fit_pen_y = (y_try > CW'(PEN_SAT)) ? PEN_SAT : y_try[PW-1:0];
        fit_sh    = '0;
      end
      if (!fail_y) begin
        fit_pen_x = x_next[PW-1:0];
        fit_sh    = (h_c > sh_eff) ? h_c[PW-1:0] : sh_eff[PW-1:0];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    shelf_h_d   = shelf_h_q;
    count_d     = count_q;
    rk_d        = rk_q;
    fk_d        = fk_q;
    dv_d        = dv_q;
    grew_d      = grew_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    rd_ok_d     = rd_ok_q;
    rd_idx_d    = rd_idx_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    size_we = 1'b0;
    size_wa = count_q[AW-1:0];
    size_wd = '{w: rect_width_i, h: rect_height_i};
    size_re = 1'b0;
    size_ra = rk_q[AW-1:0];
    pl_we   = 1'b0;
    pl_wa   = fk_q;
    pl_wd   = fit_pl;
    pl_re   = 1'b0;
    pl_ra   = ridx_ext[AW-1:0];

    fin     = 1'b0;
    fin_res = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_PLACE: begin
              if (count_q == COUNT_FULL) begin
                fin                = 1'b1;
                fin_res.side_log2  = side_q;
                fin_res.store_full = 1'b1;
              end else begin
                size_we = 1'b1;
                cur_d   = size_wd;
                idx_d   = count_q[AW-1:0];
                count_d = count_q + CNTW'(1);
                grew_d  = 1'b0;
                state_d = ST_FIT;
              end
            end
            FUNC_READ: begin
              pl_re    = 1'b1;
              rd_ok_d  = (KW'(ridx_ext) < KW'(count_q));
              rd_idx_d = read_index_i;
              state_d  = ST_READ;
            end
            FUNC_CLEAR: begin
              side_d            = start_side;
              pen_x_d           = PW'(corner_q);
              pen_y_d           = PW'(pad_q);
              shelf_h_d         = '0;
              count_d           = '0;
              fin               = 1'b1;
              fin_res.side_log2 = start_side;
            end
            default: begin
              // The unused code changes nothing and reports like a clear.
              fin               = 1'b1;
              fin_res.side_log2 = side_q;
            end
          endcase
        end
      end

      ST_FIT: begin
        pl_we = 1'b1;
        pl_wa = idx_q;
        if (fit_grow) begin
          side_d    = side_q + LOG_W'(1);
          pen_x_d   = PW'(corner_q);
          pen_y_d   = PW'(pad_q);
          shelf_h_d = '0;
          rk_d      = '0;
          dv_d      = 1'b0;
          grew_d    = 1'b1;
          state_d   = ST_REPLAY;
        end else begin
          pen_x_d             = fit_pen_x;
          pen_y_d             = fit_pen_y;
          shelf_h_d           = fit_sh;
          fin                 = 1'b1;
          fin_res.entry_index = idx_ext[IDX_W-1:0];
          fin_res.placed      = fit_pl.placed;
          fin_res.pos_x       = fit_pl.x;
          fin_res.pos_y       = fit_pl.y;
          fin_res.side_log2   = side_q;
        end
      end

      ST_REPLAY: begin
        // The read of entry k is issued in the cycle before its fit.
        if (rk_q <= CNTW'(idx_q)) begin
          size_re = 1'b1;
          rk_d    = rk_q + CNTW'(1);
          fk_d    = rk_q[AW-1:0];
          dv_d    = 1'b1;
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          pl_we = 1'b1;
          pl_wa = fk_q;
          if (fit_grow) begin
            // Failure in the replay: double again and start over from entry 0.
            side_d    = side_q + LOG_W'(1);
            pen_x_d   = PW'(corner_q);
            pen_y_d   = PW'(pad_q);
            shelf_h_d = '0;
            rk_d      = '0;
            dv_d      = 1'b0;
          end else begin
            pen_x_d   = fit_pen_x;
            pen_y_d   = fit_pen_y;
            shelf_h_d = fit_sh;
            if (fk_q == idx_q) begin
              fin                 = 1'b1;
              dv_d                = 1'b0;
              fin_res.entry_index = idx_ext[IDX_W-1:0];
              fin_res.placed      = fit_pl.placed;
              fin_res.pos_x       = fit_pl.x;
              fin_res.pos_y       = fit_pl.y;
              fin_res.side_log2   = side_q;
              fin_res.grew        = grew_q;
            end
          end
        end
      end

      ST_READ: begin
        fin                 = 1'b1;
        fin_res.entry_index = rd_idx_q;
        fin_res.placed      = rd_ok_q && place_rd_q.placed;
        fin_res.pos_x       = rd_ok_q ? place_rd_q.x : '0;
        fin_res.pos_y       = rd_ok_q ? place_rd_q.y : '0;
        fin_res.side_log2   = side_q;
      end

      ST_HOLD: begin
        if (out_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished result goes straight to the output register when it is free and
    // otherwise waits in the hold register.
    if (fin) begin
      if (out_free) begin
        out_d       = fin_res;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        hold_d  = fin_res;
        state_d = ST_HOLD;
      end
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_side_q <= INIT_SIDE_RST;
      max_side_q  <= MAX_SIDE_RST;
      pad_q       <= PAD_RST;
      corner_q    <= CORNER_RST;
      state_q     <= ST_IDLE;
      side_q      <= SIDE_RST;
      pen_x_q     <= PW'(CORNER_RST);
      pen_y_q     <= PW'(PAD_RST);
      shelf_h_q   <= '0;
      count_q     <= '0;
      rk_q        <= '0;
      fk_q        <= '0;
      dv_q        <= 1'b0;
      grew_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INIT_SIDE: init_side_q <= cfg_wdata_i[LOG_W-1:0];
          CFG_MAX_SIDE:  max_side_q  <= cfg_wdata_i[LOG_W-1:0];
          CFG_PAD:       pad_q       <= cfg_wdata_i[PAD_W-1:0];
          CFG_CORNER:    corner_q    <= cfg_wdata_i[CORNER_W-1:0];
          default:       ;
        endcase
      end
      state_q     <= state_d;
      side_q      <= side_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      shelf_h_q   <= shelf_h_d;
      count_q     <= count_d;
      rk_q        <= rk_d;
      fk_q        <= fk_d;
      dv_q        <= dv_d;
      grew_q      <= grew_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cur_q    <= cur_d;
    rd_ok_q  <= rd_ok_d;
    rd_idx_q <= rd_idx_d;
    hold_q   <= hold_d;
    out_q    <= out_d;
  end

  // Size store: written on place, read during replay.
  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (size_re) begin
      size_rd_q <= size_mem[size_ra];
    end
  end

  // Placement store: written by every fit, read by read requests.
  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      place_mem[pl_wa] <= pl_wd;
    end
    if (pl_re) begin
      place_rd_q <= place_mem[pl_ra];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_q.entry_index;
  assign placed_o      = out_q.placed;
  assign pos_x_o       = out_q.pos_x;
  assign pos_y_o       = out_q.pos_y;
  assign side_log2_o   = out_q.side_log2;
  assign grew_o        = out_q.grew;
  assign store_full_o  = out_q.store_full;

endmodule

// ----- bench/atlas_shelf_packer_with_regrow_tb.sv -----
// Self-checking testbench for the atlas shelf packer with regrow.
`timescale 1ns / 1ps

// The bench drives requests into the packer and keeps its own model of the atlas:
// the configuration registers, the side, the shelf pens, and the size and placement
// of every entry. Each accepted request is run through that model at the edge where
// it is accepted, and the predicted result joins a queue. Each result the block hands
// over is compared, field by field, with the oldest prediction in the queue.
//
// Both channels use valid/stall. Requests and configuration writes are driven with
// nonblocking assignments at the rising edge, and every handshake is sampled at the
// rising edge, so the bench only ever sees values from before the edge.
module atlas_shelf_packer_with_regrow_tb;
  import asp_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_ENTRIES_DEF;
  localparam int unsigned SIDE_CAP    = MAX_SIDE_LOG2_DEF;
  // The package names no code for the fourth function value, which the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // The slowest request is a place that doubles six times over a full store, with one
  // replay pass per doubling, plus receiver stalls. The limit leaves a wide margin over that.
  localparam int unsigned QUIET_LIMIT = 20000;
  // This many cycles after the last result are enough to see any stray result.
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 40;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_INIT_SIDE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic [FUNC_W-1:0]     func_i        = FUNC_PLACE;
  logic [DIM_W-1:0]      rect_width_i  = '0;
  logic [DIM_W-1:0]      rect_height_i = '0;
  logic [IDX_W-1:0]      read_index_i  = '0;
  logic                  out_stall_i   = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [IDX_W-1:0]      entry_index_o;
  logic                  placed_o;
  logic [POS_W-1:0]      pos_x_o;
  logic [POS_W-1:0]      pos_y_o;
  logic [LOG_W-1:0]      side_log2_o;
  logic                  grew_o;
  logic                  store_full_o;

  atlas_shelf_packer_with_regrow DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_index_o (entry_index_o),
    .placed_o      (placed_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .side_log2_o   (side_log2_o),
    .grew_o        (grew_o),
    .store_full_o  (store_full_o)
  );

  always #5 clk_i = ~clk_i;

  // Chance, in percent, that the sender idles before a request and that the
  // receiver stalls in a given cycle. The tests change these from phase to phase.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Atlas model.
  // ---------------------------------------------------------------------------

  // Copies of the configuration registers, as last written.
  logic [LOG_W-1:0]    init_side_reg;
  logic [LOG_W-1:0]    max_side_reg;
  logic [PAD_W-1:0]    pad_reg;
  logic [CORNER_W-1:0] corner_reg;

  // Current side, shelf pens and entry count.
  int unsigned atlas_log2;
  int unsigned pen_col;
  int unsigned pen_row;
  int unsigned row_height;
  int unsigned entries_held;
  // Every index below this one has been written at least once since reset. Entries
  // are always written in order from zero, so the written ones form one range.
  int unsigned high_water;

  rect_t  rect_store [STORE_DEPTH];
  place_t spot_store [STORE_DEPTH];

  result_t awaited_packings [$];
  int unsigned error_count = 0;

  // The side after a clear is the initial side held inside [minimum, cap].
  function automatic int unsigned first_side();
    if (init_side_reg < MIN_SIDE_LOG2) return MIN_SIDE_LOG2;
    if (init_side_reg > SIDE_CAP) return SIDE_CAP;
    return 32'(init_side_reg);
  endfunction

  // Growth stops at the lower of the configured maximum and the cap. A maximum that
  // is already below the side simply means no growth.
  function automatic bit can_double();
    int unsigned lim;
    lim = (max_side_reg > SIDE_CAP) ? SIDE_CAP : 32'(max_side_reg);
    return atlas_log2 < lim;
  endfunction

  function automatic void home_pens();
    pen_col    = 32'(corner_reg);
    pen_row    = 32'(pad_reg);
    row_height = 0;
  endfunction

  function automatic void wipe_atlas();
    atlas_log2   = first_side();
    home_pens();
    entries_held = 0;
  endfunction

  // Puts entry k on the current shelf at the current side. Returns 1 when the entry
  // does not fit and the atlas may still double. A wrap made before a failed height
  // check stays in place.
  function automatic bit shelve_entry(int unsigned k);
    int unsigned w, h, p, s;
    w = 32'(rect_store[k].w);
    h = 32'(rect_store[k].h);
    p = 32'(pad_reg);
    s = 1 << atlas_log2;
    spot_store[k] = '0;
    if (w == 0 || h == 0) return 1'b0;
    if (w + 2 * p > s || h + 2 * p > s) return can_double();
    if (pen_col + w + p > s) begin
      pen_col    = p;
      pen_row    = pen_row + row_height + p;
      row_height = 0;
    end
    if (pen_row + h + p > s) return can_double();
    spot_store[k].placed = 1'b1;
    spot_store[k].x      = POS_W'(pen_col);
    spot_store[k].y      = POS_W'(pen_row);
    pen_col = pen_col + w + p;
    if (h > row_height) row_height = h;
    return 1'b0;
  endfunction

  // Doubles the side and repacks entries 0 to n-1 in arrival order. A failure in the
  // middle of the replay doubles once more and starts the replay over.
  function automatic void double_and_repack(int unsigned n);
    bit again;
    int unsigned k;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      atlas_log2++;
      home_pens();
      k = 0;
      while (k < n && !again) begin
        again = shelve_entry(k);
        k++;
      end
    end
  endfunction

  // Applies one accepted request to the model and returns the result it must give.
  function automatic result_t predict_packing(logic [FUNC_W-1:0] f, logic [DIM_W-1:0] w,
                                              logic [DIM_W-1:0] h, logic [IDX_W-1:0] ri);
    result_t r;
    int unsigned k;
    r = '0;
    case (f)
      FUNC_PLACE: begin
        if (entries_held >= STORE_DEPTH) begin
          r.store_full = 1'b1;
        end else begin
          k = entries_held;
          r.entry_index = IDX_W'(k);
          rect_store[k].w = w;
          rect_store[k].h = h;
          entries_held++;
          if (entries_held > high_water) high_water = entries_held;
          if (shelve_entry(k)) begin
            double_and_repack(k + 1);
            r.grew = 1'b1;
          end
          r.placed = spot_store[k].placed;
          r.pos_x  = spot_store[k].x;
          r.pos_y  = spot_store[k].y;
        end
      end
      FUNC_READ: begin
        r.entry_index = ri;
        if (ri < entries_held) begin
          r.placed = spot_store[ri].placed;
          r.pos_x  = spot_store[ri].x;
          r.pos_y  = spot_store[ri].y;
        end
      end
      FUNC_CLEAR: begin
        wipe_atlas();
      end
      default: begin
        // The unused code changes nothing and answers like a clear.
      end
    endcase
    r.side_log2 = LOG_W'(atlas_log2);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------

  // Appends one prediction at the tail of the queue of awaited results.
  function automatic void queue_packing(result_t r);
    awaited_packings.insert(awaited_packings.size(), r);
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want,
                             logic [IDX_W-1:0] entry);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h (entry %0d)", name, got, want,
                                entry));
    end
  endtask

  // One process tracks configuration writes, predicts each accepted request, checks
  // each accepted result and runs the watchdog. Doing all of it in one block fixes
  // the order: a request accepted at an edge is predicted before a result accepted
  // at the same edge is checked.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : packing_monitor
    result_t want;
    bit took_in;
    bit took_out;
    if (!rst_ni) begin
      init_side_reg = INIT_SIDE_RST;
      max_side_reg  = MAX_SIDE_RST;
      pad_reg       = PAD_RST;
      corner_reg    = CORNER_RST;
      high_water    = 0;
      wipe_atlas();
      quiet_cycles  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INIT_SIDE: init_side_reg = cfg_wdata_i[LOG_W-1:0];
          CFG_MAX_SIDE:  max_side_reg  = cfg_wdata_i[LOG_W-1:0];
          CFG_PAD:       pad_reg       = cfg_wdata_i[PAD_W-1:0];
          CFG_CORNER:    corner_reg    = cfg_wdata_i[CORNER_W-1:0];
          default: ;
        endcase
      end
      took_in  = in_valid_i && !in_stall_o;
      took_out = out_valid_o && !out_stall_i;
      if (took_in) begin
        queue_packing(predict_packing(func_i, rect_width_i, rect_height_i,
                                      read_index_i));
      end
      if (took_out) begin
        if (awaited_packings.size() == 0) begin
          report_mismatch("result arrived with no request waiting for one");
        end else begin
          want = awaited_packings.pop_front();
          check_field("entry_index", 16'(entry_index_o), 16'(want.entry_index),
                      want.entry_index);
          check_field("placed", 16'(placed_o), 16'(want.placed), want.entry_index);
          check_field("pos_x", 16'(pos_x_o), 16'(want.pos_x), want.entry_index);
          check_field("pos_y", 16'(pos_y_o), 16'(want.pos_y), want.entry_index);
          check_field("side_log2", 16'(side_log2_o), 16'(want.side_log2),
                      want.entry_index);
          check_field("grew", 16'(grew_o), 16'(want.grew), want.entry_index);
          check_field("store_full", 16'(store_full_o), 16'(want.store_full),
                      want.entry_index);
        end
      end
      if (took_in || took_out) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, awaited_packings.size());
        $display("atlas_shelf_packer_with_regrow_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving.
  // ---------------------------------------------------------------------------

  // Sends one request and returns at the edge where it is accepted. Valid is left
  // high, so a request that follows at once keeps it high without a glitch; the
  // idle loop of the next request, or the drain below, is what lowers it.
  task automatic send_request(logic [FUNC_W-1:0] f, logic [DIM_W-1:0] w,
                              logic [DIM_W-1:0] h, logic [IDX_W-1:0] ri);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    rect_width_i  <= w;
    rect_height_i <= h;
    read_index_i  <= ri;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has been handed over.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_packings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all four registers while the block is idle. The upper bits of the data
  // bus are random for the narrow registers, since the block must ignore them.
  task automatic set_config(logic [LOG_W-1:0] init_lg, logic [LOG_W-1:0] max_lg,
                            logic [PAD_W-1:0] pad, logic [CORNER_W-1:0] corner);
    wait_results_done();
    write_reg(CFG_INIT_SIDE, {2'($urandom), init_lg});
    write_reg(CFG_MAX_SIDE, {2'($urandom), max_lg});
    write_reg(CFG_PAD, {2'($urandom), pad});
    write_reg(CFG_CORNER, corner);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small sizes, a share of mid-sized ones, a few zeros and a few values
  // anywhere in the 13-bit range, which are often too big for any atlas.
  function automatic logic [DIM_W-1:0] random_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return DIM_W'($urandom);
    if (r < 8) return '0;
    if (r < 20) return DIM_W'($urandom_range(1024, 1));
    return DIM_W'($urandom_range(48, 1));
  endfunction

  function automatic logic [DIM_W-1:0] tiny_dim();
    if ($urandom_range(4) == 0) return '0;
    return DIM_W'($urandom_range(24, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset configuration: side 1024, pad 2, first shelf starting at x = 8. Also
  // zero-sized entries in either dimension and the unused function code.
  task automatic test_reset_values();
    send_request(FUNC_PLACE, 13'd30, 13'd20, 10'($urandom));
    send_request(FUNC_PLACE, 13'd0, 13'd5, 10'($urandom));
    send_request(FUNC_PLACE, 13'd7, 13'd0, 10'($urandom));
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd0);
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd2);
    send_request(FUNC_UNUSED, 13'($urandom), 13'($urandom), 10'($urandom));
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd0);
  endtask

  // No pad and no corner at the largest side: a 4096 square fills the atlas
  // exactly, after which nothing fits and the side may not grow.
  task automatic test_exact_fit();
    set_config(4'd12, 4'd12, 4'd0, 6'd0);
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
    send_request(FUNC_PLACE, 13'd4096, 13'd4096, 10'($urandom));
    send_request(FUNC_PLACE, 13'd1, 13'd1, 10'($urandom));
    send_request(FUNC_PLACE, 13'd8191, 13'd8191, 10'($urandom));
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd0);
  endtask

  // Smallest side (the initial value below the minimum), widest pad and corner: the
  // first rectangle wraps at once, the second forces a regrow, and the oversized
  // ones grow the atlas up to the cap and are still left unplaced.
  task automatic test_regrow_chain();
    set_config(4'd3, 4'd15, 4'd15, 6'd63);
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
    send_request(FUNC_PLACE, 13'd10, 13'd10, 10'($urandom));
    send_request(FUNC_PLACE, 13'd40, 13'd40, 10'($urandom));
    send_request(FUNC_PLACE, 13'd8191, 13'd1, 10'($urandom));
    send_request(FUNC_PLACE, 13'd1, 13'd8191, 10'($urandom));
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd1);
  endtask

  // The maximum side lies below the current one, so a rectangle that does not fit
  // stays unplaced, and a failed height check keeps its shelf wrap.
  task automatic test_growth_blocked();
    set_config(4'd7, 4'd4, 4'd7, 6'd1);
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
    send_request(FUNC_PLACE, 13'd200, 13'd10, 10'($urandom));
    send_request(FUNC_PLACE, 13'd60, 13'd60, 10'($urandom));
    send_request(FUNC_PLACE, 13'd60, 13'd60, 10'($urandom));
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd1);
  endtask

  // After a clear, entries that still sit in the store read back as unplaced.
  task automatic test_clear_forgets();
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
    send_request(FUNC_READ, 13'($urandom), 13'($urandom), 10'd3);
  endtask

  // Fills the whole entry store with small rectangles starting at a 256 side, so
  // the atlas regrows with long replays on the way. Places past the last entry are
  // refused; afterwards every index is written and may be read. The idling pattern
  // changes every quarter of the fill.
  task automatic test_store_full();
    int unsigned k;
    set_config(4'd8, 4'd12, 4'd1, 6'd5);
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
    for (k = 0; k < STORE_DEPTH; k++) begin
      case (k / (STORE_DEPTH / 4))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      send_request(FUNC_PLACE, tiny_dim(), tiny_dim(), 10'($urandom));
    end
    for (k = 0; k < 4; k++) begin
      send_request(FUNC_PLACE, random_dim(), random_dim(), 10'($urandom));
    end
    for (k = 0; k < 12; k++) begin
      send_request(FUNC_READ, 13'($urandom), 13'($urandom),
                   10'($urandom_range(STORE_DEPTH - 1)));
    end
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
  endtask

  // One phase of random traffic under one configuration and one idling pattern:
  // mostly places, reads of written entries (in range or left over from before a
  // clear), occasional clears so the store stays short, the unused code now and
  // then, and every so often a pause until all results are back.
  task automatic run_random_segment(int unsigned count, int unsigned gap,
                                    int unsigned stall, logic [LOG_W-1:0] init_lg,
                                    logic [LOG_W-1:0] max_lg, logic [PAD_W-1:0] pad,
                                    logic [CORNER_W-1:0] corner);
    int unsigned sent;
    int unsigned pick;
    logic [IDX_W-1:0] idx;
    sent = 0;
    set_config(init_lg, max_lg, pad, corner);
    gap_pct   = gap;
    stall_pct = stall;
    send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
    while (sent < count) begin
      if ($urandom_range(99) < 2) wait_results_done();
      pick = $urandom_range(99);
      if (pick < 70 || high_water == 0) begin
        send_request(FUNC_PLACE, random_dim(), random_dim(), 10'($urandom));
      end else if (pick < 90) begin
        if (entries_held != 0 && $urandom_range(3) != 0)
          idx = IDX_W'($urandom_range(entries_held - 1));
        else
          idx = IDX_W'($urandom_range(high_water - 1));
        send_request(FUNC_READ, 13'($urandom), 13'($urandom), idx);
      end else if (pick < 96) begin
        send_request(FUNC_CLEAR, 13'($urandom), 13'($urandom), 10'($urandom));
      end else begin
        send_request(FUNC_UNUSED, 13'($urandom), 13'($urandom), 10'($urandom));
      end
      sent++;
    end
  endtask

  task automatic test_random_mix();
    run_random_segment(48, 0, 0, 4'd10, 4'd12, 4'd2, 6'd8);
    run_random_segment(48, 59, 0, 4'd0, 4'd15, 4'd0, 6'd0);
    run_random_segment(48, 0, 59, 4'd15, 4'd0, 4'd15, 6'd63);
    run_random_segment(48, 30, 30, 4'd6, 4'd6, 4'd4, 6'd32);
    run_random_segment(48, 0, 0, 4'($urandom), 4'($urandom), 4'($urandom), 6'($urandom));
    run_random_segment(48, 59, 0, 4'($urandom), 4'($urandom), 4'($urandom),
                       6'($urandom));
    run_random_segment(48, 0, 59, 4'($urandom), 4'($urandom), 4'($urandom),
                       6'($urandom));
    run_random_segment(48, 30, 30, 4'($urandom), 4'($urandom), 4'($urandom),
                       6'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_exact_fit();
    test_regrow_chain();
    test_growth_blocked();
    test_clear_forgets();
    test_store_full();
    test_random_mix();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("atlas_shelf_packer_with_regrow_tb OK");
    end else begin
      $display("atlas_shelf_packer_with_regrow_tb NOT OK");
    end
    $finish;
  end

endmodule
